[hdl/moam_pkg.sv]
// Shared types and constants for the mask outline and alpha marker.
`default_nettype none
package moam_pkg;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_OUTLINE_COLOR = 2'd2,
      CSR_FILL_ALPHA    = 2'd3
   } csr_index_type;

   localparam int unsigned PIXEL_BITS    = 32;
   localparam int unsigned SIZE_BITS     = 13;
   localparam int unsigned COLOR_BITS    = 24;
   localparam int unsigned ALPHA_BITS    = 8;
   localparam int unsigned CSR_DATA_BITS = 24;

   localparam logic [ALPHA_BITS-1:0] OUTLINE_ALPHA = 8'hff;
   localparam logic [SIZE_BITS-1:0]  RESET_SIZE    = 13'd64;
   localparam logic [ALPHA_BITS-1:0] RESET_ALPHA   = 8'd255;
   localparam logic [SIZE_BITS-1:0]  MIN_SIZE      = 13'd2;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  run_last;
      logic                  frame_end;
   } rsp_word_type;

endpackage
`default_nettype wire

[hdl/mask_outline_alpha_marker.sv]
// Outline marking and alpha insertion for a raster area mask, one row delay.
// Takes one pixel per clock while req_ready is high. Rows 1 to height-2 give one result
// word per pixel, so the block sustains one pixel per cycle there if rsp_ready stays high;
// the last row, two words per pixel, is paced by the queue draining one word a cycle.
// Row 0 gives no words. The row buffer is a MAX_WIDTH x 32 memory with one write and one
// registered read per cycle; the next column is read ahead, with forwarding of a write to
// the same entry. Width and height are sampled at the first pixel of each frame and are
// saturated to 2 .. MAX_WIDTH and 2 .. MAX_HEIGHT. No clearing pass after reset.
`default_nettype none
module mask_outline_alpha_marker #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [moam_pkg::PIXEL_BITS-1:0]     req_pixel_in,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [moam_pkg::PIXEL_BITS-1:0]     rsp_pixel_out,
   output      logic                                rsp_run_last,
   output      logic                                rsp_frame_end,
   input  wire logic                                csr_write_enable,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [moam_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int unsigned XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned SB = moam_pkg::SIZE_BITS;
   localparam int unsigned CWW = (WW > SB) ? WW : SB;
   localparam int unsigned CHW = (HW > SB) ? HW : SB;
   localparam int unsigned PB = moam_pkg::PIXEL_BITS;

   // configuration
   logic [SB-1:0]                      image_width_ff;
   logic [SB-1:0]                      image_height_ff;
   logic [moam_pkg::COLOR_BITS-1:0]    outline_color_ff;
   logic [moam_pkg::ALPHA_BITS-1:0]    fill_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= moam_pkg::RESET_SIZE;
         image_height_ff  <= moam_pkg::RESET_SIZE;
         outline_color_ff <= '0;
         fill_alpha_ff    <= moam_pkg::RESET_ALPHA;
      end else if (csr_write_enable) begin
         case (moam_pkg::csr_index_type'(csr_index))
            moam_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_write_data[SB-1:0];
            end
            moam_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_write_data[SB-1:0];
            end
            moam_pkg::CSR_OUTLINE_COLOR: begin
               outline_color_ff <= csr_write_data[moam_pkg::COLOR_BITS-1:0];
            end
            moam_pkg::CSR_FILL_ALPHA: begin
               fill_alpha_ff <= csr_write_data[moam_pkg::ALPHA_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // saturated frame size
   logic [CWW-1:0] width_ext;
   logic [CHW-1:0] height_ext;
   logic [WW-1:0]  width_sat;
   logic [HW-1:0]  height_sat;

   always_comb begin
      width_ext  = CWW'(image_width_ff);
      height_ext = CHW'(image_height_ff);
      if (width_ext < CWW'(moam_pkg::MIN_SIZE)) begin
         width_sat = WW'(moam_pkg::MIN_SIZE);
      end else if (width_ext > CWW'(MAX_WIDTH)) begin
         width_sat = WW'(MAX_WIDTH);
      end else begin
         width_sat = width_ext[WW-1:0];
      end
      if (height_ext < CHW'(moam_pkg::MIN_SIZE)) begin
         height_sat = HW'(moam_pkg::MIN_SIZE);
      end else if (height_ext > CHW'(MAX_HEIGHT)) begin
         height_sat = HW'(MAX_HEIGHT);
      end else begin
         height_sat = height_ext[HW-1:0];
      end
   end

   // scan state
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [WW-1:0] frame_w_ff, frame_w_in;
   logic [HW-1:0] frame_h_ff, frame_h_in;
   logic [PB-1:0] left_pending_ff, left_pending_in;
   logic          left_zero_ff, left_zero_in;
   logic [PB-1:0] last_col_ff, last_col_in;
   logic [PB-1:0] rd_data_ff;

   // row buffer
   logic [PB-1:0] row_mem [MAX_WIDTH];
   logic          mem_we;
   logic [XW-1:0] mem_waddr;
   logic [PB-1:0] mem_wdata;
   logic [XW-1:0] mem_raddr;

   // output queue
   moam_pkg::rsp_word_type fifo_ff [4];
   logic [1:0]             wr_ptr_ff, rd_ptr_ff;
   logic [2:0]             count_ff, count_in;

   logic                   accept;
   logic                   pop;
   logic                   frame_start;
   logic                   row_end;
   logic                   last_row;
   logic                   cz;
   logic [PB-1:0]          outline_value;
   logic [PB-1:0]          up;
   logic [PB-1:0]          prov;
   logic                   push_first;
   logic                   push_second;
   moam_pkg::rsp_word_type word_first;
   moam_pkg::rsp_word_type word_second;

   assign req_ready = (count_ff <= 3'd2);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      frame_start   = (col_ff == '0) && (row_ff == '0);
      frame_w_in    = frame_start ? width_sat  : frame_w_ff;
      frame_h_in    = frame_start ? height_sat : frame_h_ff;
      row_end       = ((WW'(col_ff) + WW'(1)) == frame_w_in);
      last_row      = ((HW'(row_ff) + HW'(1)) == frame_h_in);
      cz            = (req_pixel_in == '0);
      outline_value = {moam_pkg::OUTLINE_ALPHA, outline_color_ff};

      if (row_ff == '0) begin
         up = '0;
      end else if (row_end) begin
         up = last_col_ff;
      end else begin
         up = rd_data_ff;
      end

      // word for the pixel above: lower and lower-left rule
      word_first.pixel = up;
      if ((up != '0) && (col_ff != '0) && cz && left_zero_ff &&
          (((HW + 1)'(row_ff) + (HW + 1)'(2)) <= (HW + 1)'(frame_h_in))) begin
         word_first.pixel = outline_value;
      end
      word_first.run_last  = !last_row;
      word_first.frame_end = 1'b0;

      // left pixel settles by the right-neighbor rule
      mem_we    = accept && (col_ff != '0);
      mem_waddr = col_ff - XW'(1);
      mem_wdata = (cz && !left_zero_ff) ? outline_value : left_pending_ff;

      if (cz) begin
         prov = '0;
      end else if ((row_ff == '0) || last_row || (col_ff == '0) || left_zero_ff ||
                   (up == '0)) begin
         prov = outline_value;
      end else begin
         prov = req_pixel_in | {fill_alpha_ff, 24'd0};
      end

      word_second.pixel     = prov;
      word_second.run_last  = 1'b1;
      word_second.frame_end = row_end;

      push_first  = accept && (row_ff != '0);
      push_second = accept && last_row;

      last_col_in = (accept && row_end) ? prov : last_col_ff;

      if (row_end) begin
         col_in          = '0;
         left_pending_in = '0;
         left_zero_in    = 1'b1;
         row_in          = last_row ? '0 : (row_ff + YW'(1));
      end else begin
         col_in          = col_ff + XW'(1);
         left_pending_in = prov;
         left_zero_in    = cz;
         row_in          = row_ff;
      end
      mem_raddr = col_in;

      count_in = count_ff - {2'd0, pop} + {2'd0, push_first} + {2'd0, push_second};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff          <= '0;
         row_ff          <= '0;
         left_pending_ff <= '0;
         left_zero_ff    <= 1'b1;
      end else if (accept) begin
         col_ff          <= col_in;
         row_ff          <= row_in;
         left_pending_ff <= left_pending_in;
         left_zero_ff    <= left_zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
      end
      last_col_ff <= last_col_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (mem_we && (mem_waddr == mem_raddr)) begin
            rd_data_ff <= mem_wdata;
         end else begin
            rd_data_ff <= row_mem[mem_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + {1'b0, push_first} + {1'b0, push_second};
         rd_ptr_ff <= rd_ptr_ff + {1'b0, pop};
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         fifo_ff[wr_ptr_ff] <= word_first;
      end
      if (push_second) begin
         fifo_ff[wr_ptr_ff + {1'b0, push_first}] <= word_second;
      end
   end

   assign rsp_pixel_out = fifo_ff[rd_ptr_ff].pixel;
   assign rsp_run_last  = fifo_ff[rd_ptr_ff].run_last;
   assign rsp_frame_end = fifo_ff[rd_ptr_ff].frame_end;

endmodule
`default_nettype wire

[sim/mask_outline_alpha_marker_test.sv]
// Testbench for mask_outline_alpha_marker: outline and alpha prediction checked word by word.
`timescale 1ns / 1ps
module mask_outline_alpha_marker_test;

   localparam int unsigned MAX_WIDTH     = 4096;
   localparam int unsigned MAX_HEIGHT    = 4096;
   localparam int unsigned XW            = $clog2(MAX_WIDTH);
   localparam int unsigned RANDOM_ITEMS  = 1500;
   localparam int unsigned WIDE_ITEMS    = 64;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned STALL_LIMIT   = 2000;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [moam_pkg::PIXEL_BITS-1:0]    req_pixel_in = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [moam_pkg::PIXEL_BITS-1:0]    rsp_pixel_out;
   logic                               rsp_run_last;
   logic                               rsp_frame_end;
   logic                               csr_write_enable = 1'b0;
   moam_pkg::csr_index_type            csr_index = moam_pkg::CSR_IMAGE_WIDTH;
   logic [moam_pkg::CSR_DATA_BITS-1:0] csr_write_data = '0;

   // stimulus and scoreboard
   logic [moam_pkg::PIXEL_BITS-1:0] mask_pixels [$];
   moam_pkg::rsp_word_type          marked_pixels [$];
   logic                            req_taken = 1'b0;
   logic                            rsp_taken = 1'b0;
   int unsigned                     send_gap = 0;
   int unsigned                     rsp_stall = 0;
   bit                              quiet_flow = 1'b0;
   int unsigned                     error_count = 0;
   int unsigned                     stall_cycles = 0;
   logic                            watchdog_expired = 1'b0;
   int unsigned                     next_w = 2;
   int unsigned                     next_h = 2;
   bit                              size_pending = 1'b0;

   // predictor copy of the registers and of the marking state
   logic [moam_pkg::SIZE_BITS-1:0]  size_w_reg = moam_pkg::RESET_SIZE;
   logic [moam_pkg::SIZE_BITS-1:0]  size_h_reg = moam_pkg::RESET_SIZE;
   logic [moam_pkg::COLOR_BITS-1:0] outline_rgb = '0;
   logic [moam_pkg::ALPHA_BITS-1:0] fill_alpha_reg = moam_pkg::RESET_ALPHA;
   int unsigned                     col_pos = 0;
   int unsigned                     row_pos = 0;
   int unsigned                     frame_w = 64;
   int unsigned                     frame_h = 64;
   logic [moam_pkg::PIXEL_BITS-1:0] row_store [0:MAX_WIDTH-1];
   logic [moam_pkg::PIXEL_BITS-1:0] left_held = '0;
   logic                            left_zero = 1'b1;

   mask_outline_alpha_marker #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_run_last    (rsp_run_last),
      .rsp_frame_end   (rsp_frame_end),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned fit_size(logic [moam_pkg::SIZE_BITS-1:0] raw,
                                            int unsigned top);
      if (raw < moam_pkg::MIN_SIZE) return 32'(moam_pkg::MIN_SIZE);
      if (raw > top) return top;
      return 32'(raw);
   endfunction

   function automatic int unsigned idle_draw();
      return quiet_flow ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic void mark_pixel(logic [moam_pkg::PIXEL_BITS-1:0] pix);
      logic [moam_pkg::PIXEL_BITS-1:0] outline;
      logic [moam_pkg::PIXEL_BITS-1:0] up_val;
      logic [moam_pkg::PIXEL_BITS-1:0] held;
      logic [moam_pkg::PIXEL_BITS-1:0] prov;
      logic                            cz;
      int unsigned                     x;
      int unsigned                     y;
      moam_pkg::rsp_word_type          word;
      outline = {moam_pkg::OUTLINE_ALPHA, outline_rgb};
      cz = (pix == '0);
      if (col_pos == 0 && row_pos == 0) begin
         frame_w = fit_size(size_w_reg, MAX_WIDTH);
         frame_h = fit_size(size_h_reg, MAX_HEIGHT);
      end
      x = (col_pos >= frame_w) ? frame_w - 1 : col_pos;
      y = (row_pos >= frame_h) ? frame_h - 1 : row_pos;
      up_val = (y >= 1) ? row_store[XW'(x)] : '0;
      if (y >= 1) begin
         held = up_val;
         if (held != '0 && x >= 1 && y + 2 <= frame_h && cz && left_zero)
            held = outline;
         word.pixel     = held;
         word.run_last  = (y + 1 != frame_h);
         word.frame_end = 1'b0;
         marked_pixels.push_back(word);
      end
      // settle the left pixel by its right neighbor, then store it
      if (x >= 1) begin
         if (cz && !left_zero)
            left_held = outline;
         row_store[XW'(x - 1)] = left_held;
      end
      if (cz)
         prov = '0;
      else if (y == 0 || y + 1 == frame_h || x == 0 || left_zero || up_val == '0)
         prov = outline;
      else
         prov = pix | {fill_alpha_reg, 24'h000000};
      if (x + 1 == frame_w)
         row_store[XW'(x)] = prov;
      if (y + 1 == frame_h) begin
         word.pixel     = prov;
         word.run_last  = 1'b1;
         word.frame_end = (x + 1 == frame_w);
         marked_pixels.push_back(word);
      end
      left_held = prov;
      left_zero = cz;
      if (x + 1 >= frame_w) begin
         col_pos   = 0;
         left_held = '0;
         left_zero = 1'b1;
         row_pos   = (y + 1 >= frame_h) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
         row_pos = y;
      end
   endfunction

   // sample both channels
   always @(posedge clock) begin : check_words
      moam_pkg::rsp_word_type want;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (marked_pixels.size() == 0) begin
            error_count++;
            if (error_count <= 20)
               $display("%0t unexpected word: expected none, actual pixel %h last %b end %b",
                        $time, rsp_pixel_out, rsp_run_last, rsp_frame_end);
         end else begin
            want = marked_pixels.pop_front();
            if ({rsp_pixel_out, rsp_run_last, rsp_frame_end} !== want) begin
               error_count++;
               if (error_count <= 20)
                  $display({"%0t mismatch: expected pixel %h last %b end %b, ",
                            "actual pixel %h last %b end %b"},
                           $time, want.pixel, want.run_last, want.frame_end,
                           rsp_pixel_out, rsp_run_last, rsp_frame_end);
            end
         end
      end
      if (!reset && req_valid && req_ready)
         mark_pixel(req_pixel_in);
      stall_cycles <= ((rsp_valid && rsp_ready) || (req_valid && req_ready)) ?
                      0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT)
         watchdog_expired <= 1'b1;
   end

   // drive the pixel channel
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (mask_pixels.size() != 0) begin
            req_valid    <= 1'b1;
            req_pixel_in <= mask_pixels.pop_front();
            send_gap     <= idle_draw();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // drive backpressure on the result channel
   always @(negedge clock) begin : recv_side
      int unsigned hold_now;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         hold_now = rsp_taken ? idle_draw() : rsp_stall;
         if (hold_now != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall <= hold_now - 1;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall <= 0;
         end
      end
   end

   task automatic write_register(moam_pkg::csr_index_type idx,
                                 logic [moam_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         moam_pkg::CSR_IMAGE_WIDTH:   size_w_reg = data[moam_pkg::SIZE_BITS-1:0];
         moam_pkg::CSR_IMAGE_HEIGHT:  size_h_reg = data[moam_pkg::SIZE_BITS-1:0];
         moam_pkg::CSR_OUTLINE_COLOR: outline_rgb = data[moam_pkg::COLOR_BITS-1:0];
         moam_pkg::CSR_FILL_ALPHA:    fill_alpha_reg = data[moam_pkg::ALPHA_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // hold until every pixel is taken and every word has come, then let the pipe empty
   task automatic drain_and_wait();
      while (mask_pixels.size() != 0 || req_valid || marked_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic choose_size();
      logic [moam_pkg::CSR_DATA_BITS-1:0] data_w;
      logic [moam_pkg::CSR_DATA_BITS-1:0] data_h;
      data_w = 24'($urandom);
      data_h = 24'($urandom);
      if ($urandom_range(0, 9) == 0)
         data_w[moam_pkg::SIZE_BITS-1:0] = 13'($urandom_range(0, 1));
      else
         data_w[moam_pkg::SIZE_BITS-1:0] =
            13'($urandom_range(2, ($urandom_range(0, 4) == 0) ? 40 : 12));
      if ($urandom_range(0, 9) == 0)
         data_h[moam_pkg::SIZE_BITS-1:0] = 13'($urandom_range(0, 1));
      else
         data_h[moam_pkg::SIZE_BITS-1:0] =
            13'($urandom_range(2, ($urandom_range(0, 4) == 0) ? 16 : 8));
      write_register(moam_pkg::CSR_IMAGE_WIDTH, data_w);
      write_register(moam_pkg::CSR_IMAGE_HEIGHT, data_h);
      next_w = fit_size(data_w[moam_pkg::SIZE_BITS-1:0], MAX_WIDTH);
      next_h = fit_size(data_h[moam_pkg::SIZE_BITS-1:0], MAX_HEIGHT);
   endtask

   task automatic retune_colors();
      logic [moam_pkg::CSR_DATA_BITS-1:0] rgb;
      logic [moam_pkg::CSR_DATA_BITS-1:0] alpha_word;
      rgb = 24'($urandom);
      alpha_word = 24'($urandom);
      case ($urandom_range(0, 3))
         0: rgb = '0;
         1: rgb = 24'hffffff;
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0: alpha_word[moam_pkg::ALPHA_BITS-1:0] = '0;
         1: alpha_word[moam_pkg::ALPHA_BITS-1:0] = 8'hff;
         default: ;
      endcase
      write_register(moam_pkg::CSR_OUTLINE_COLOR, rgb);
      write_register(moam_pkg::CSR_FILL_ALPHA, alpha_word);
   endtask

   task automatic queue_pixels(int unsigned w, int unsigned h, int unsigned count, bit allow_split);
      int unsigned                     split_at;
      int unsigned                     shape;
      int unsigned                     rx0;
      int unsigned                     rx1;
      int unsigned                     ry0;
      int unsigned                     ry1;
      int unsigned                     x;
      int unsigned                     y;
      int unsigned                     i;
      logic [moam_pkg::PIXEL_BITS-1:0] value;
      bit                              filled;
      split_at = (allow_split && $urandom_range(0, 2) == 0) ? $urandom_range(1, count - 1) : 0;
      shape = $urandom_range(0, 3);
      rx0 = $urandom_range(0, w - 1);
      rx1 = $urandom_range(rx0, w - 1);
      ry0 = $urandom_range(0, h - 1);
      ry1 = $urandom_range(ry0, h - 1);
      for (i = 0; i < count; i++) begin
         if (split_at != 0 && i == split_at) begin
            drain_and_wait();
            retune_colors();
            if ($urandom_range(0, 1) == 1) begin
               choose_size();
               size_pending = 1'b1;
            end
         end
         x = i % w;
         y = i / w;
         case (shape)
            0: filled = ($urandom_range(0, 9) < 3);
            1: filled = ($urandom_range(0, 9) < 8);
            2: filled = (x >= rx0 && x <= rx1 && y >= ry0 && y <= ry1)
                        ^ ($urandom_range(0, 19) == 0);
            default: filled = 1'b1;
         endcase
         case ($urandom_range(0, 3))
            0: value = $urandom;
            1: value = {8'h00, 24'($urandom)};
            2: value = 32'hffffffff;
            default: value = $urandom_range(1, 255);
         endcase
         if (!filled)
            value = '0;
         else if (value == '0)
            value = 32'h00000001;
         mask_pixels.push_back(value);
      end
   endtask

   initial begin : stimulus
      int unsigned                        random_count;
      int unsigned                        cur_w;
      int unsigned                        cur_h;
      logic [moam_pkg::CSR_DATA_BITS-1:0] big_w;
      random_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 4x4 frame with reset colors: edges, neighbor rules, lower and lower-left rule
      write_register(moam_pkg::CSR_IMAGE_WIDTH, 24'd4);
      write_register(moam_pkg::CSR_IMAGE_HEIGHT, 24'd4);
      mask_pixels = {32'h00000005, 32'h00a0b0c0, 32'h7fffffff, 32'h00000000,
                     32'h00123456, 32'h00000002, 32'h80000003, 32'h00000004,
                     32'h00000000, 32'h00000000, 32'h00000009, 32'h00000000,
                     32'hffffffff, 32'h00000000, 32'h00000001, 32'h00ffffff};
      drain_and_wait();

      // sizes below range saturate to 2x2, extreme color and alpha
      write_register(moam_pkg::CSR_IMAGE_WIDTH, 24'hffe001);
      write_register(moam_pkg::CSR_IMAGE_HEIGHT, 24'h00e000);
      write_register(moam_pkg::CSR_OUTLINE_COLOR, 24'hffffff);
      write_register(moam_pkg::CSR_FILL_ALPHA, 24'hab0000);
      mask_pixels = {32'hffffffff, 32'h00000001, 32'h80000000, 32'h00000000};
      drain_and_wait();

      choose_size();
      retune_colors();
      while (random_count < RANDOM_ITEMS) begin
         cur_w = next_w;
         cur_h = next_h;
         size_pending = 1'b0;
         quiet_flow = ($urandom_range(0, 4) == 0);
         queue_pixels(cur_w, cur_h, cur_w * cur_h, 1'b1);
         random_count += cur_w * cur_h;
         if (!size_pending && $urandom_range(0, 2) != 0) begin
            drain_and_wait();
            choose_size();
            if ($urandom_range(0, 1) == 1)
               retune_colors();
         end
      end

      // largest frame, width above range and height at the maximum: the start of the top row
      drain_and_wait();
      quiet_flow = 1'b0;
      big_w = 24'($urandom);
      big_w[moam_pkg::SIZE_BITS-1:0] = 13'h1fff;
      write_register(moam_pkg::CSR_IMAGE_WIDTH, big_w);
      write_register(moam_pkg::CSR_IMAGE_HEIGHT, 24'd4096);
      queue_pixels(MAX_WIDTH, MAX_HEIGHT, WIDE_ITEMS, 1'b0);
      drain_and_wait();

      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : watchdog
      wait (watchdog_expired);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
